// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 package
// S-box tables, GF(2^8) helpers and opcode constants for the block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW  = 1'b1;

  typedef logic [127:0] state_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  // Byte b of the state is row b%4, column b/4; byte 0 is in bits 127:120.
  function automatic logic [7:0] get_b(input state_t s, input int b);
    get_b = s[127-8*b -: 8];
  endfunction

  function automatic state_t sub_shift(input state_t s, input logic inv);
    state_t o;
    int src;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[127-8*(4*c+r) -: 8] = inv ? inv_sbox(get_b(s, 4*src+r)) : sbox(get_b(s, 4*src+r));
      end
    end
    sub_shift = o;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv)
        o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      else
        o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
    end
    mix_col = o;
  endfunction

  function automatic state_t mix_cols(input state_t s, input logic inv);
    state_t o;
    for (int c = 0; c < 4; c++) o[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    mix_cols = o;
  endfunction

endpackage

// ===== design/aes128_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Iterative encrypt/decrypt of one 128-bit word with a stored round-key schedule.
// ----------------------------------------------------------------------------
// One word is processed at a time. After a key write the first word first
// expands the schedule, one key word per cycle, with each complete round key
// written to an eleven-entry memory once its fourth word is known, and then
// reads back the first round key. Each word then passes through these steps:
// acceptance, which also reads the first round key; adding that key; ten
// rounds through the one shared round unit, with the next round key read
// from memory in each round; and showing the result, which is held while
// the output is stalled. The input is stalled from acceptance until the
// result has been taken.
module aes128_block_cipher import aes_pkg::*; #(
  parameter int ROUND_COUNT = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);

  localparam int WordCount = 4 * (ROUND_COUNT + 1);
  localparam int WW = $clog2(WordCount + 1);
  localparam int RW = $clog2(ROUND_COUNT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXP  = 3'd1;
  localparam logic [2:0] ST_K0   = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    st_r;
  logic [63:0]   key_hi_r, key_lo_r;
  logic          sched_ok_r;
  logic [127:0]  rk_mem [ROUND_COUNT + 1];
  logic [127:0]  rk_rd_r;
  logic [WW-1:0] widx_r;
  logic [31:0]   win_r [4];
  logic [7:0]    rcon_r;
  logic [RW-1:0] rnd_r;
  logic          dec_r;
  state_t        s_r;
  logic [127:0]  blk_r;
  logic [RW-1:0] rd_rnd;
  logic          is_last;

  // Expansion: next word from the sliding window of the last four.
  logic [31:0] t_w, new_w;
  always_comb begin
    t_w = win_r[3];
    if (widx_r[1:0] == 2'd0)
      t_w = {sbox(win_r[3][23:16]), sbox(win_r[3][15:8]), sbox(win_r[3][7:0]),
             sbox(win_r[3][31:24])} ^ {rcon_r, 24'd0};
    new_w = win_r[0] ^ t_w;
  end

  assign is_last = dec_r ? (rnd_r == '0) : (rnd_r == RW'(ROUND_COUNT));

  // Round key wanted in the next cycle.
  always_comb begin
    rd_rnd = rnd_r;
    case (st_r)
      ST_IDLE: rd_rnd = (in_opcode == OP_DECRYPT) ? RW'(ROUND_COUNT) : '0;
      ST_K0, ST_RND: begin
        if (!is_last) rd_rnd = dec_r ? rnd_r - RW'(1) : rnd_r + RW'(1);
      end
      default: rd_rnd = rnd_r;
    endcase
  end

  // A whole round key is written once its fourth word is known.
  always_ff @(posedge clk) begin
    rk_rd_r <= rk_mem[rd_rnd];
    if (st_r == ST_EXP && widx_r[1:0] == 2'd3) begin
      if (widx_r < WW'(4)) rk_mem[RW'(widx_r >> 2)] <= {win_r[0], win_r[1], win_r[2], win_r[3]};
      else                 rk_mem[RW'(widx_r >> 2)] <= {win_r[1], win_r[2], win_r[3], new_w};
    end
  end

  state_t rnd_in, rnd_out;
  always_comb begin
    rnd_in = sub_shift(s_r, dec_r);
    if (is_last)      rnd_out = rnd_in ^ rk_rd_r;
    else if (dec_r)   rnd_out = mix_cols(rnd_in ^ rk_rd_r, 1'b1);
    else              rnd_out = mix_cols(rnd_in, 1'b0) ^ rk_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      sched_ok_r <= 1'b0;
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else begin
      if (cfg_we) begin
        sched_ok_r <= 1'b0;
        if (cfg_index == CFG_KEY_HIGH) key_hi_r <= cfg_data;
        else                           key_lo_r <= cfg_data;
      end else if (st_r == ST_EXP && widx_r == WW'(WordCount)) begin
        sched_ok_r <= 1'b1;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_valid) begin
            dec_r <= in_opcode;
            blk_r <= {in_block_high, in_block_low};
            rnd_r <= (in_opcode == OP_DECRYPT) ? RW'(ROUND_COUNT) : '0;
            if (sched_ok_r) st_r <= ST_K0;
            else begin
              st_r <= ST_EXP;
              widx_r <= '0;
              rcon_r <= 8'h01;
              win_r[0] <= key_hi_r[63:32];
              win_r[1] <= key_hi_r[31:0];
              win_r[2] <= key_lo_r[63:32];
              win_r[3] <= key_lo_r[31:0];
            end
          end
        end
        ST_EXP: begin
          if (widx_r >= WW'(4)) begin
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2] <= win_r[3];
            win_r[3] <= new_w;
            if (widx_r[1:0] == 2'd0) rcon_r <= xtime(rcon_r);
          end
          widx_r <= widx_r + WW'(1);
          // The step after the last word reads the first round key back.
          if (widx_r == WW'(WordCount)) st_r <= ST_K0;
        end
        ST_K0: begin
          s_r <= blk_r ^ rk_rd_r;
          rnd_r <= rd_rnd;
          st_r <= ST_RND;
        end
        ST_RND: begin
          s_r <= rnd_out;
          if (is_last) st_r <= ST_OUT;
          else rnd_r <= rd_rnd;
        end
        ST_OUT: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall        = (st_r != ST_IDLE);
  assign out_valid       = (st_r == ST_OUT);
  assign out_result_high = s_r[127:64];
  assign out_result_low  = s_r[63:0];

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while input open");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(s_r)) else $error("result lost");
  a_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RND) |-> sched_ok_r || cfg_we || $past(cfg_we)) else $error("no schedule");

endmodule
